/* design/zhne_pkg.sv */
// shared types and constants of the zip header name extractor
package zhne_pkg;

  localparam logic [23:0] SIG_HEAD3     = 24'h504B03;
  localparam logic [7:0]  SIG_LAST      = 8'h04;
  localparam logic [4:0]  OFS_LEN_LO    = 5'd26;
  localparam logic [4:0]  OFS_LEN_HI    = 5'd27;
  localparam logic [4:0]  OFS_HDR_LAST  = 5'd29;
  localparam logic [4:0]  OFS_AFTER_SIG = 5'd4;

  typedef enum logic [1:0] {
    K_NAME    = 2'd0,
    K_END     = 2'd1,
    K_VERDICT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    PH_SCAN   = 3'b001,
    PH_HEADER = 3'b010,
    PH_NAME   = 3'b100
  } phase_t;

  // results of one input item: a first result, optionally followed by end of name
  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
    logic       found;
    logic       two;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* design/zhne_front.sv */
// front part: byte scan, header offset tracking and result classification
module zhne_front import zhne_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_value,
  input  logic       in_last_of_file,
  output logic       push,
  output job_t       push_job,
  input  q_stat_t    q_stat
);

  logic [23:0] recent_r, recent_nxt;
  phase_t      phase_r, phase_nxt;
  logic [4:0]  hdr_off_r, hdr_off_nxt;
  logic [15:0] name_len_r, name_len_nxt;
  logic [15:0] name_left_r, name_left_nxt;
  logic        seen_r, seen_nxt;

  logic accept;
  logic has0;
  logic closed;
  logic end_needed;
  job_t job;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  always_comb begin
    recent_nxt    = recent_r;
    phase_nxt     = phase_r;
    hdr_off_nxt   = hdr_off_r;
    name_len_nxt  = name_len_r;
    name_left_nxt = name_left_r;
    seen_nxt      = seen_r;
    has0          = 1'b0;
    closed        = 1'b0;
    end_needed    = 1'b0;
    job.kind      = K_END;
    job.ch        = 8'd0;
    job.found     = 1'b0;
    job.two       = 1'b0;

    unique case (phase_r)
      PH_HEADER: begin
        if (hdr_off_r == OFS_LEN_LO) begin
          name_len_nxt = {name_len_r[15:8], in_byte_value};
        end else if (hdr_off_r == OFS_LEN_HI) begin
          name_len_nxt = {in_byte_value, name_len_r[7:0]};
        end
        if (hdr_off_r >= OFS_HDR_LAST) begin
          if (name_len_nxt == 16'd0) begin
            has0      = 1'b1;
            job.kind  = K_END;
            closed    = 1'b1;
            phase_nxt = PH_SCAN;
          end else begin
            name_left_nxt = name_len_nxt;
            phase_nxt     = PH_NAME;
          end
          hdr_off_nxt = 5'd0;
        end else begin
          hdr_off_nxt = hdr_off_r + 5'd1;
        end
      end
      PH_NAME: begin
        has0          = 1'b1;
        job.kind      = K_NAME;
        job.ch        = in_byte_value;
        name_left_nxt = name_left_r - 16'd1;
        if (name_left_nxt == 16'd0) begin
          job.two   = 1'b1;
          closed    = 1'b1;
          phase_nxt = PH_SCAN;
        end
      end
      default: begin
        phase_nxt = PH_SCAN;
        if (recent_r == SIG_HEAD3 && in_byte_value == SIG_LAST) begin
          if (!seen_r) begin
            has0      = 1'b1;
            job.kind  = K_VERDICT;
            job.found = 1'b1;
          end
          seen_nxt      = 1'b1;
          recent_nxt    = 24'd0;
          phase_nxt     = PH_HEADER;
          hdr_off_nxt   = OFS_AFTER_SIG;
          name_len_nxt  = 16'd0;
          name_left_nxt = 16'd0;
        end else begin
          recent_nxt = {recent_r[15:0], in_byte_value};
        end
      end
    endcase

    if (in_last_of_file) begin
      // close a name cut off by end of file
      end_needed = !closed && (phase_nxt == PH_NAME ||
                               (phase_nxt == PH_HEADER && hdr_off_nxt > OFS_LEN_HI));
      if (end_needed) begin
        if (has0) begin
          job.two = 1'b1;
        end else begin
          has0     = 1'b1;
          job.kind = K_END;
        end
      end
      // no signature in this file: only possible with no other result
      if (!seen_nxt) begin
        has0      = 1'b1;
        job.kind  = K_VERDICT;
        job.found = 1'b0;
      end
      recent_nxt    = 24'd0;
      phase_nxt     = PH_SCAN;
      hdr_off_nxt   = 5'd0;
      name_len_nxt  = 16'd0;
      name_left_nxt = 16'd0;
      seen_nxt      = 1'b0;
    end
  end

  assign push     = accept && has0;
  assign push_job = job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recent_r    <= 24'd0;
      phase_r     <= PH_SCAN;
      hdr_off_r   <= 5'd0;
      name_len_r  <= 16'd0;
      name_left_r <= 16'd0;
      seen_r      <= 1'b0;
    end else if (accept) begin
      recent_r    <= recent_nxt;
      phase_r     <= phase_nxt;
      hdr_off_r   <= hdr_off_nxt;
      name_len_r  <= name_len_nxt;
      name_left_r <= name_left_nxt;
      seen_r      <= seen_nxt;
    end
  end

endmodule

/* design/zhne_fifo.sv */
// short job queue between front and back parts
module zhne_fifo import zhne_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head_job,
  output q_stat_t q_stat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push;
  logic          do_pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_job     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* design/zhne_back.sv */
// back part: turns queued jobs into result items, one a cycle while out_stall is low
module zhne_back import zhne_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       head_job,
  input  q_stat_t    q_stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_name_char,
  output logic       out_archive_found,
  output logic       out_final_of_run
);

  // set while the trailing end of name of the head job is shown
  logic sel_r, sel_nxt;
  logic take;

  assign out_valid         = !q_stat.empty;
  assign take              = out_valid && !out_stall;
  assign out_kind          = sel_r ? K_END : head_job.kind;
  assign out_name_char     = sel_r ? 8'd0 : head_job.ch;
  assign out_archive_found = sel_r ? 1'b0 : head_job.found;
  assign out_final_of_run  = sel_r || !head_job.two;
  assign pop               = take && (sel_r || !head_job.two);

  always_comb begin
    sel_nxt = sel_r;
    if (take) begin
      sel_nxt = !sel_r && head_job.two;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
    end else begin
      sel_r <= sel_nxt;
    end
  end

endmodule

/* design/zip_header_name_extractor.sv */
// top level of the zip local header name extractor
//
//  channel  dir  handshake            payload
//  in_      in   in_valid / in_stall  in_byte_value, in_last_of_file
//  out_     out  out_valid/out_stall  out_kind, out_name_char,
//                                     out_archive_found, out_final_of_run
//
// one byte accepted per cycle while in_stall is low; its results leave the queue
// from the next cycle on; a byte giving a name byte and end of name yields two items
// the job queue of FIFO_DEPTH entries absorbs that; in_stall rises only when it is full
// synchronous active-low reset clears scan state, queue pointers and output sequencer
// output stall only backs up the queue; the front keeps taking bytes until it fills
module zip_header_name_extractor import zhne_pkg::*; #(
  parameter int FIFO_DEPTH = 2   // queue entries, 2 to 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte_value,
  input  logic       in_last_of_file,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_name_char,
  output logic       out_archive_found,
  output logic       out_final_of_run
);

  // front to queue
  logic    push;
  job_t    push_job;
  // queue to back
  logic    pop;
  job_t    head_job;
  q_stat_t q_stat;

  // signature match, header offsets, name length capture
  zhne_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte_value   (in_byte_value),
    .in_last_of_file (in_last_of_file),
    .push            (push),
    .push_job        (push_job),
    .q_stat          (q_stat)
  );

  // decouples byte intake from result delivery
  zhne_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  // emits one or two result items per job
  zhne_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_job          (head_job),
    .q_stat            (q_stat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_name_char     (out_name_char),
    .out_archive_found (out_archive_found),
    .out_final_of_run  (out_final_of_run)
  );

endmodule

/* design/zhne_checker.sv */
// port-level checks of the zip header name extractor, bound to the top level
module zhne_checker import zhne_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_name_char,
  input logic       out_archive_found,
  input logic       out_final_of_run
);

  // a non-final item is a name byte and its end of name follows at once
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_final_of_run
      |=> out_valid && out_kind == K_END && out_final_of_run)
    else $error("end of name does not follow a non-final item");

  a_nonfinal_is_name: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_final_of_run |-> out_kind == K_NAME)
    else $error("non-final item is not a name byte");

  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != K_NAME |-> out_name_char == 8'd0)
    else $error("name char set on a non-name item");

  a_found_only_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != K_VERDICT |-> !out_archive_found)
    else $error("archive found set on a non-verdict item");

endmodule

bind zip_header_name_extractor zhne_checker u_zhne_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_kind          (out_kind),
  .out_name_char     (out_name_char),
  .out_archive_found (out_archive_found),
  .out_final_of_run  (out_final_of_run)
);
